@@ rtl/rtlsc_pkg.sv @@
package rtlsc_pkg;

   // cache geometry
   localparam int NUM_SLOTS  = 8;
   localparam int SLOT_BYTES = 256;
   localparam int SLOT_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int FILL_W     = $clog2(SLOT_BYTES + 1);

   // field widths
   localparam int OFF_W   = 24;
   localparam int CNT_W   = 16;
   localparam int ADDR_W  = 25;
   localparam int CLK_W   = 32;
   localparam int CSR_A_W = 3;
   localparam int CSR_D_W = 24;

   // result status codes
   localparam logic [1:0] STATUS_REJECT = 2'd0;
   localparam logic [1:0] STATUS_HIT    = 2'd1;
   localparam logic [1:0] STATUS_MISS   = 2'd2;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_READY       = 3'd0;
   localparam logic [CSR_A_W-1:0] CSR_FIRST_SIZE  = 3'd1;
   localparam logic [CSR_A_W-1:0] CSR_FIRST_BASE  = 3'd2;
   localparam logic [CSR_A_W-1:0] CSR_SECOND_SIZE = 3'd3;
   localparam logic [CSR_A_W-1:0] CSR_SECOND_BASE = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic begin_walk;
      logic step;
      logic reply_reject;
      logic reply_hit;
      logic reply_miss;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic reject;
      logic hit;
      logic last;
   } sts_type;

endpackage

@@ rtl/rtlsc_ctrl.sv @@
module rtlsc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  rtlsc_pkg::sts_type sts,
   output rtlsc_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHECK = 2'd1;
   localparam logic [1:0] ST_WALK  = 2'd2;

   logic [1:0] state_ff, state_in;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (sts.reject) begin
               cmd.reply_reject = 1'b1;
               state_in         = ST_IDLE;
            end else begin
               cmd.begin_walk = 1'b1;
               state_in       = ST_WALK;
            end
         end
         ST_WALK: begin
            if (sts.hit) begin
               cmd.reply_hit = 1'b1;
               state_in      = ST_IDLE;
            end else if (sts.last) begin
               cmd.reply_miss = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   // an accepted item always goes to the range check
   a_load_check: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CHECK))
      else $error("accepted item did not enter range check");

   // a reply always returns the controller to idle
   a_reply_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.reply_reject || cmd.reply_hit || cmd.reply_miss) |=> !busy)
      else $error("controller busy after reply");

   // walk step and reply never together
   a_step_excl: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !(cmd.reply_hit || cmd.reply_miss))
      else $error("walk step issued with a reply");

endmodule

@@ rtl/rtlsc_datapath.sv @@
module rtlsc_datapath (
   input  logic                              clock,
   input  logic                              reset,
   // configuration writes
   input  logic                              csr_write,
   input  logic [rtlsc_pkg::CSR_A_W-1:0]     csr_index,
   input  logic [rtlsc_pkg::CSR_D_W-1:0]     csr_data,
   // request fields
   input  logic                              req_source_select,
   input  logic [rtlsc_pkg::OFF_W-1:0]       req_byte_offset,
   input  logic [rtlsc_pkg::CNT_W-1:0]       req_byte_count,
   // control
   input  rtlsc_pkg::cmd_type                cmd,
   output rtlsc_pkg::sts_type                sts,
   // result
   output logic                              rsp_valid,
   output logic [1:0]                        rsp_status,
   output logic [2:0]                        rsp_slot_index,
   output logic [7:0]                        rsp_offset_in_slot,
   output logic [rtlsc_pkg::ADDR_W-1:0]      rsp_fill_address,
   output logic [8:0]                        rsp_fill_size
);

   localparam int N  = rtlsc_pkg::NUM_SLOTS;
   localparam int SW = rtlsc_pkg::SLOT_W;
   localparam int FW = rtlsc_pkg::FILL_W;
   localparam int OW = rtlsc_pkg::OFF_W;
   localparam int AW = rtlsc_pkg::ADDR_W;
   localparam int CW = rtlsc_pkg::CLK_W;

   // configuration registers
   logic          ready_ff;
   logic [OW-1:0] size0_ff, base0_ff, size1_ff, base1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         size0_ff <= '0;
         base0_ff <= '0;
         size1_ff <= '0;
         base1_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            rtlsc_pkg::CSR_READY:       ready_ff <= csr_data[0];
            rtlsc_pkg::CSR_FIRST_SIZE:  size0_ff <= csr_data;
            rtlsc_pkg::CSR_FIRST_BASE:  base0_ff <= csr_data;
            rtlsc_pkg::CSR_SECOND_SIZE: size1_ff <= csr_data;
            rtlsc_pkg::CSR_SECOND_BASE: base1_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // latched request
   logic                         src_ff;
   logic [OW-1:0]                off_ff;
   logic [rtlsc_pkg::CNT_W-1:0]  cnt_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         src_ff <= req_source_select;
         off_ff <= req_byte_offset;
         cnt_ff <= req_byte_count;
      end
   end

   // range check, end of request and fill geometry
   logic [OW-1:0] size_sel, base_sel, left;
   logic [AW-1:0] req_end, fill_addr;
   logic [FW-1:0] fill_len;
   logic          chk_reject;

   always_comb begin
      size_sel  = src_ff ? size1_ff : size0_ff;
      base_sel  = src_ff ? base1_ff : base0_ff;
      req_end   = {1'b0, off_ff} + AW'(cnt_ff);
      fill_addr = {1'b0, base_sel} + {1'b0, off_ff};
      left      = size_sel - off_ff;
      if (left > OW'(rtlsc_pkg::SLOT_BYTES)) begin
         fill_len = FW'(rtlsc_pkg::SLOT_BYTES);
      end else begin
         fill_len = FW'(left);
      end
      chk_reject = !ready_ff || (cnt_ff == '0) ||
                   (cnt_ff > rtlsc_pkg::CNT_W'(rtlsc_pkg::SLOT_BYTES)) ||
                   (req_end > {1'b0, size_sel});
   end

   logic [AW-1:0] req_end_ff, fill_addr_ff;
   logic [FW-1:0] fill_len_ff;

   always_ff @(posedge clock) begin
      if (cmd.begin_walk) begin
         req_end_ff   <= req_end;
         fill_addr_ff <= fill_addr;
         fill_len_ff  <= fill_len;
      end
   end

   // slot tags
   logic          valid_ff    [N];
   logic          source_ff   [N];
   logic [OW-1:0] start_ff    [N];
   logic [FW-1:0] fbytes_ff   [N];
   logic [CW-1:0] last_use_ff [N];
   logic [CW-1:0] use_clock_ff;

   // walk position and victim tracking
   logic [SW-1:0] idx_ff, idx_in;
   logic [SW-1:0] vic_ff, vic_in;
   logic [CW-1:0] vic_use_ff, vic_use_in;
   logic          vic_done_ff, vic_done_in;

   logic          cur_valid;
   logic [CW-1:0] cur_use;
   logic [AW-1:0] cur_end;
   logic [OW-1:0] cur_start;
   logic          cur_hit;
   logic          cur_last;

   always_comb begin
      cur_valid = valid_ff[idx_ff];
      cur_use   = last_use_ff[idx_ff];
      cur_start = start_ff[idx_ff];
      cur_end   = {1'b0, cur_start} + AW'(fbytes_ff[idx_ff]);
      cur_hit   = cur_valid && (source_ff[idx_ff] == src_ff) &&
                  (off_ff >= cur_start) && (req_end_ff <= cur_end);
      cur_last  = (idx_ff == SW'(N - 1));
      idx_in    = idx_ff + SW'(1);
   end

   // status to the controller, in field order reject, hit, last
   assign sts = {chk_reject, cur_hit, cur_last};

   // first invalid slot, else the first smallest last use
   always_comb begin
      vic_in      = vic_ff;
      vic_use_in  = vic_use_ff;
      vic_done_in = vic_done_ff;
      if (idx_ff == '0) begin
         vic_in      = '0;
         vic_use_in  = cur_use;
         vic_done_in = !cur_valid;
      end else if (!vic_done_ff) begin
         if (!cur_valid) begin
            vic_in      = idx_ff;
            vic_done_in = 1'b1;
         end else if (cur_use < vic_use_ff) begin
            vic_in     = idx_ff;
            vic_use_in = cur_use;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.begin_walk) begin
         idx_ff <= '0;
      end else if (cmd.step) begin
         idx_ff      <= idx_in;
         vic_ff      <= vic_in;
         vic_use_ff  <= vic_use_in;
         vic_done_ff <= vic_done_in;
      end
   end

   // use clock and tag updates
   always_ff @(posedge clock) begin
      if (reset) begin
         use_clock_ff <= '0;
         for (int i = 0; i < N; i++) begin
            valid_ff[i]    <= 1'b0;
            last_use_ff[i] <= '0;
         end
      end else begin
         if (cmd.begin_walk) begin
            use_clock_ff <= use_clock_ff + CW'(1);
         end
         if (cmd.reply_hit) begin
            last_use_ff[idx_ff] <= use_clock_ff;
         end
         if (cmd.reply_miss) begin
            valid_ff[vic_in]    <= 1'b1;
            last_use_ff[vic_in] <= use_clock_ff;
         end
      end
   end

   // unreset tag payload
   always_ff @(posedge clock) begin
      if (cmd.reply_miss) begin
         source_ff[vic_in] <= src_ff;
         start_ff[vic_in]  <= off_ff;
         fbytes_ff[vic_in] <= fill_len_ff;
      end
   end

   // result register
   logic       rsp_valid_ff;
   logic [1:0] status_ff;
   logic [2:0] slot_ff;
   logic [7:0] in_slot_ff;
   logic [AW-1:0] addr_ff;
   logic [8:0] size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.reply_reject || cmd.reply_hit || cmd.reply_miss;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.reply_reject) begin
         status_ff  <= rtlsc_pkg::STATUS_REJECT;
         slot_ff    <= '0;
         in_slot_ff <= '0;
         addr_ff    <= '0;
         size_ff    <= '0;
      end else if (cmd.reply_hit) begin
         status_ff  <= rtlsc_pkg::STATUS_HIT;
         slot_ff    <= 3'(idx_ff);
         in_slot_ff <= 8'(off_ff - cur_start);
         addr_ff    <= '0;
         size_ff    <= '0;
      end else if (cmd.reply_miss) begin
         status_ff  <= rtlsc_pkg::STATUS_MISS;
         slot_ff    <= 3'(vic_in);
         in_slot_ff <= '0;
         addr_ff    <= fill_addr_ff;
         size_ff    <= 9'(fill_len_ff);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_slot_index     = slot_ff;
   assign rsp_offset_in_slot = in_slot_ff;
   assign rsp_fill_address   = addr_ff;
   assign rsp_fill_size      = size_ff;

endmodule

@@ rtl/range_tagged_lru_slot_cache.sv @@
// Tag and LRU replacement controller for a small fully associative read
// cache over two flash sources. A request is taken when start is high and
// busy is low; its result appears on the rsp_ ports for exactly one cycle
// with rsp_valid high and must be captured then, since the receiver cannot
// stall the block. A rejected request is answered from the range check
// alone; a valid request walks the tags one slot per clock from slot 0
// and is answered at the first matching slot or, on a miss, after the
// last slot. The next request may be taken in the cycle its predecessor's
// result is shown. Configuration writes are always ready and should be
// made only while busy is low and no result is pending.
module range_tagged_lru_slot_cache (
   input  logic                          clock,
   input  logic                          reset,
   // request
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_source_select,
   input  logic [rtlsc_pkg::OFF_W-1:0]   req_byte_offset,
   input  logic [rtlsc_pkg::CNT_W-1:0]   req_byte_count,
   // result
   output logic                          rsp_valid,
   output logic [1:0]                    rsp_status,
   output logic [2:0]                    rsp_slot_index,
   output logic [7:0]                    rsp_offset_in_slot,
   output logic [rtlsc_pkg::ADDR_W-1:0]  rsp_fill_address,
   output logic [8:0]                    rsp_fill_size,
   // configuration
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [rtlsc_pkg::CSR_A_W-1:0] csr_index,
   input  logic [rtlsc_pkg::CSR_D_W-1:0] csr_data
);

   rtlsc_pkg::cmd_type cmd;
   rtlsc_pkg::sts_type sts;

   assign csr_ready = 1'b1;

   rtlsc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   rtlsc_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .csr_write          (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_source_select  (req_source_select),
      .req_byte_offset    (req_byte_offset),
      .req_byte_count     (req_byte_count),
      .cmd                (cmd),
      .sts                (sts),
      .rsp_valid          (rsp_valid),
      .rsp_status         (rsp_status),
      .rsp_slot_index     (rsp_slot_index),
      .rsp_offset_in_slot (rsp_offset_in_slot),
      .rsp_fill_address   (rsp_fill_address),
      .rsp_fill_size      (rsp_fill_size)
   );

   // every item passes through idle and the range check, so strobes never touch
   a_strobe_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // a result only follows a busy cycle
   a_strobe_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a pending item");

   // a miss always fills at least one byte
   a_miss_fill: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == rtlsc_pkg::STATUS_MISS)) |-> (rsp_fill_size != '0))
      else $error("miss with empty fill");

endmodule
